@@ sv/bitp_pkg.sv @@
// ----------------------------------------------------------------------------
// bitp_pkg
// Shared types, codes and sizes of the boolean infix-to-postfix converter.
// ----------------------------------------------------------------------------
package bitp_pkg;

    // Default operator stack depth
    localparam int STACK_DEPTH_DEF = 16;

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int ACTION_W = 3;
    localparam int VAR_W    = 16;
    localparam int POS_W    = 16;
    localparam int TYPE_W   = 2;
    localparam int ENTRY_W  = TYPE_W + POS_W;

    // Raw input action codes
    localparam logic [ACTION_W-1:0] ACT_VAR = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_OR  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_AND = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_NOT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_LBR = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_RBR = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_END = 3'd6;

    // Stack entry types, also the output token types for operators
    localparam logic [TYPE_W-1:0] STK_LBR = 2'd0;
    localparam logic [TYPE_W-1:0] STK_OR  = 2'd1;
    localparam logic [TYPE_W-1:0] STK_AND = 2'd2;
    localparam logic [TYPE_W-1:0] STK_NOT = 2'd3;
    localparam logic [TYPE_W-1:0] TOK_VAR = 2'd0;

    // Result kinds
    localparam logic [1:0] KIND_TOKEN  = 2'd0;
    localparam logic [1:0] KIND_ERROR  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_UNEXP_VAR  = 3'd1;
    localparam logic [2:0] ERR_UNEXP_TOK  = 3'd2;
    localparam logic [2:0] ERR_MIXED      = 3'd3;
    localparam logic [2:0] ERR_OPEN_CLOSE = 3'd4;
    localparam logic [2:0] ERR_UNFINISHED = 3'd5;
    localparam logic [2:0] ERR_OPEN_LEFT  = 3'd6;
    localparam logic [2:0] ERR_OVERFLOW   = 3'd7;

    // Classified operation
    typedef enum logic [2:0] {
        OP_VAR,
        OP_OR,
        OP_AND,
        OP_NOT,
        OP_LBR,
        OP_RBR,
        OP_END
    } t_op;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VAR_W-1:0]    variable_id;
        logic [POS_W-1:0]    position;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TYPE_W-1:0] token_type;
        logic [VAR_W-1:0]  token_variable;
        logic [2:0]        error_code;
        logic [POS_W-1:0]  error_position;
        logic              last;
    } t_out_item;

    typedef struct packed {
        t_op              op;
        logic [VAR_W-1:0] var_id;
        logic [POS_W-1:0] pos;
    } t_cls_item;

endpackage

@@ sv/bitp_front.sv @@
// ----------------------------------------------------------------------------
// bitp_front
// Input stage: accept a token, classify its action, drop the unused code.
// ----------------------------------------------------------------------------
module bitp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bitp_pkg::t_in_item   i_in_item,
    output logic                 o_cls_valid,
    input  logic                 i_cls_ready,
    output bitp_pkg::t_cls_item  o_cls_item
);

    logic                r_valid;
    logic                n_valid;
    bitp_pkg::t_cls_item r_item;
    bitp_pkg::t_cls_item n_item;
    logic                known;
    bitp_pkg::t_op       op;

    always_comb begin
        known = 1'b1;
        op    = bitp_pkg::OP_VAR;
        case (i_in_item.action)
            bitp_pkg::ACT_VAR: op = bitp_pkg::OP_VAR;
            bitp_pkg::ACT_OR:  op = bitp_pkg::OP_OR;
            bitp_pkg::ACT_AND: op = bitp_pkg::OP_AND;
            bitp_pkg::ACT_NOT: op = bitp_pkg::OP_NOT;
            bitp_pkg::ACT_LBR: op = bitp_pkg::OP_LBR;
            bitp_pkg::ACT_RBR: op = bitp_pkg::OP_RBR;
            bitp_pkg::ACT_END: op = bitp_pkg::OP_END;
            default:           known = 1'b0;
        endcase
    end

    assign o_in_ready  = !r_valid || i_cls_ready;
    assign o_cls_valid = r_valid;
    assign o_cls_item  = r_item;

    always_comb begin
        n_valid = r_valid && !i_cls_ready;
        n_item  = r_item;
        if (i_in_valid && o_in_ready && known) begin
            n_valid       = 1'b1;
            n_item.op     = op;
            n_item.var_id = i_in_item.variable_id;
            n_item.pos    = i_in_item.position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

@@ sv/bitp_queue.sv @@
// ----------------------------------------------------------------------------
// bitp_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module bitp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_valid,
    output logic                 o_wr_ready,
    input  bitp_pkg::t_cls_item  i_wr_item,
    output logic                 o_rd_valid,
    input  logic                 i_rd_ready,
    output bitp_pkg::t_cls_item  o_rd_item
);

    bitp_pkg::t_cls_item               r_slot [bitp_pkg::QUEUE_DEPTH];
    logic [bitp_pkg::QUEUE_AW-1:0]     r_wr_ptr;
    logic [bitp_pkg::QUEUE_AW-1:0]     r_rd_ptr;
    logic [bitp_pkg::QUEUE_CW-1:0]     r_fill;
    logic                              wr;
    logic                              rd;

    assign o_wr_ready = r_fill != bitp_pkg::QUEUE_CW'(bitp_pkg::QUEUE_DEPTH);
    assign o_rd_valid = r_fill != '0;
    assign o_rd_item  = r_slot[r_rd_ptr];
    assign wr         = i_wr_valid && o_wr_ready;
    assign rd         = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_fill <= r_fill + 1'b1;
            end else if (rd && !wr) begin
                r_fill <= r_fill - 1'b1;
            end
        end
        if (wr) begin
            r_slot[r_wr_ptr] <= i_wr_item;
        end
    end

endmodule

@@ sv/bitp_back.sv @@
// ----------------------------------------------------------------------------
// bitp_back
// Shunting-yard sequencer: operator stack, error latch and result output.
// ----------------------------------------------------------------------------
module bitp_back #(
    parameter int STACK_DEPTH = bitp_pkg::STACK_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_ready,
    input  bitp_pkg::t_cls_item  i_q_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bitp_pkg::t_out_item  o_out_item
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    // Stack memory: one write port, one registered read port at the top
    logic [bitp_pkg::ENTRY_W-1:0] r_mem [STACK_DEPTH];
    logic [bitp_pkg::ENTRY_W-1:0] r_rd;
    logic [IW-1:0]                rd_idx;
    logic [CW-1:0]                cnt_m1;

    bitp_pkg::t_state    r_state, n_state;
    bitp_pkg::t_cls_item r_cur, n_cur;
    logic [CW-1:0]       r_count, n_count;
    logic                r_expect, n_expect;
    logic                r_seen, n_seen;
    logic [2:0]          r_latched, n_latched;
    logic                r_top_ok, n_top_ok;
    bitp_pkg::t_out_item r_hold, n_hold;
    logic                r_hold_v, n_hold_v;
    bitp_pkg::t_out_item r_out, n_out;
    logic                r_out_v, n_out_v;

    logic                          has;
    logic                          full;
    logic [bitp_pkg::TYPE_W-1:0]   top_type;
    logic [bitp_pkg::POS_W-1:0]    top_pos;
    logic [bitp_pkg::TYPE_W-1:0]   bin_t;
    logic                          out_free;
    logic                          can_emit;
    logic                          step;
    logic                          emit;
    bitp_pkg::t_out_item           em;
    logic                          push;
    logic [bitp_pkg::ENTRY_W-1:0]  push_data;
    logic                          pop;
    logic                          clear;
    logic                          mv;
    logic                          mv_last;
    logic                          deq;

    assign has      = r_count != '0;
    assign full     = r_count == CW'(STACK_DEPTH);
    assign top_type = r_rd[bitp_pkg::ENTRY_W-1:bitp_pkg::POS_W];
    assign top_pos  = r_rd[bitp_pkg::POS_W-1:0];
    assign cnt_m1   = r_count - 1'b1;
    assign rd_idx   = has ? cnt_m1[IW-1:0] : '0;
    assign out_free = !r_out_v || i_out_ready;
    assign can_emit = !r_hold_v || out_free;
    assign bin_t    = (r_cur.op == bitp_pkg::OP_OR) ? bitp_pkg::STK_OR : bitp_pkg::STK_AND;
    assign step     = can_emit && (!has || r_top_ok);

    assign o_q_ready   = deq;
    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_count   = r_count;
        n_expect  = r_expect;
        n_seen    = r_seen;
        n_latched = r_latched;
        emit      = 1'b0;
        em        = '0;
        push      = 1'b0;
        push_data = '0;
        pop       = 1'b0;
        clear     = 1'b0;
        mv_last   = 1'b0;
        deq       = 1'b0;
        case (r_state)
            bitp_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    deq     = 1'b1;
                    n_cur   = i_q_item;
                    n_state = bitp_pkg::ST_RUN;
                end
            end
            bitp_pkg::ST_RUN: begin
                if (step) begin
                    if (r_cur.op == bitp_pkg::OP_END) begin
                        n_state = bitp_pkg::ST_FINAL;
                        if (r_latched == bitp_pkg::ERR_NONE && r_seen) begin
                            if (r_expect) begin
                                emit              = 1'b1;
                                em.kind           = bitp_pkg::KIND_ERROR;
                                em.error_code     = bitp_pkg::ERR_UNFINISHED;
                                em.error_position = r_cur.pos;
                                n_latched         = bitp_pkg::ERR_UNFINISHED;
                            end else if (has && top_type != bitp_pkg::STK_LBR) begin
                                // flush one operator, stay here
                                emit          = 1'b1;
                                em.token_type = top_type;
                                pop           = 1'b1;
                                n_state       = bitp_pkg::ST_RUN;
                            end else if (has) begin
                                emit              = 1'b1;
                                em.kind           = bitp_pkg::KIND_ERROR;
                                em.error_code     = bitp_pkg::ERR_OPEN_LEFT;
                                em.error_position = top_pos;
                                n_latched         = bitp_pkg::ERR_OPEN_LEFT;
                            end
                        end
                    end else if (r_latched != bitp_pkg::ERR_NONE) begin
                        n_state = bitp_pkg::ST_DONE;
                    end else begin
                        n_seen  = 1'b1;
                        n_state = bitp_pkg::ST_DONE;
                        case (r_cur.op)
                            bitp_pkg::OP_VAR: begin
                                emit = 1'b1;
                                if (!r_expect) begin
                                    em.kind           = bitp_pkg::KIND_ERROR;
                                    em.error_code     = bitp_pkg::ERR_UNEXP_VAR;
                                    em.error_position = r_cur.pos;
                                    n_latched         = bitp_pkg::ERR_UNEXP_VAR;
                                end else begin
                                    em.token_type     = bitp_pkg::TOK_VAR;
                                    em.token_variable = r_cur.var_id;
                                    n_expect          = 1'b0;
                                end
                            end
                            bitp_pkg::OP_OR, bitp_pkg::OP_AND: begin
                                if (r_expect) begin
                                    emit              = 1'b1;
                                    em.kind           = bitp_pkg::KIND_ERROR;
                                    em.error_code     = bitp_pkg::ERR_UNEXP_TOK;
                                    em.error_position = r_cur.pos;
                                    n_latched         = bitp_pkg::ERR_UNEXP_TOK;
                                end else if (has && top_type == bitp_pkg::STK_NOT) begin
                                    // pending negations bind tighter: pop them first
                                    emit          = 1'b1;
                                    em.token_type = top_type;
                                    pop           = 1'b1;
                                    n_state       = bitp_pkg::ST_RUN;
                                end else if (has && top_type != bitp_pkg::STK_LBR &&
                                             top_type != bin_t) begin
                                    emit              = 1'b1;
                                    em.kind           = bitp_pkg::KIND_ERROR;
                                    em.error_code     = bitp_pkg::ERR_MIXED;
                                    em.error_position = r_cur.pos;
                                    n_latched         = bitp_pkg::ERR_MIXED;
                                end else begin
                                    n_expect = 1'b1;
                                    if (full) begin
                                        emit              = 1'b1;
                                        em.kind           = bitp_pkg::KIND_ERROR;
                                        em.error_code     = bitp_pkg::ERR_OVERFLOW;
                                        em.error_position = r_cur.pos;
                                        n_latched         = bitp_pkg::ERR_OVERFLOW;
                                    end else begin
                                        push      = 1'b1;
                                        push_data = {bin_t, r_cur.pos};
                                    end
                                end
                            end
                            bitp_pkg::OP_NOT, bitp_pkg::OP_LBR: begin
                                if (!r_expect || full) begin
                                    emit              = 1'b1;
                                    em.kind           = bitp_pkg::KIND_ERROR;
                                    em.error_code     = !r_expect ? bitp_pkg::ERR_UNEXP_TOK
                                                                  : bitp_pkg::ERR_OVERFLOW;
                                    em.error_position = r_cur.pos;
                                    n_latched         = em.error_code;
                                end else begin
                                    push      = 1'b1;
                                    push_data = {(r_cur.op == bitp_pkg::OP_NOT) ?
                                                 bitp_pkg::STK_NOT : bitp_pkg::STK_LBR,
                                                 r_cur.pos};
                                end
                            end
                            bitp_pkg::OP_RBR: begin
                                if (r_expect || !has) begin
                                    emit              = 1'b1;
                                    em.kind           = bitp_pkg::KIND_ERROR;
                                    em.error_code     = r_expect ? bitp_pkg::ERR_UNEXP_TOK
                                                                 : bitp_pkg::ERR_OPEN_CLOSE;
                                    em.error_position = r_cur.pos;
                                    n_latched         = em.error_code;
                                end else if (top_type != bitp_pkg::STK_LBR) begin
                                    emit          = 1'b1;
                                    em.token_type = top_type;
                                    pop           = 1'b1;
                                    n_state       = bitp_pkg::ST_RUN;
                                end else begin
                                    // drop the matching bracket
                                    pop = 1'b1;
                                end
                            end
                            default: begin
                                n_state = bitp_pkg::ST_DONE;
                            end
                        endcase
                    end
                end
            end
            bitp_pkg::ST_FINAL: begin
                if (can_emit) begin
                    emit          = 1'b1;
                    em.kind       = bitp_pkg::KIND_STATUS;
                    em.error_code = r_latched;
                    clear         = 1'b1;
                    n_count       = '0;
                    n_expect      = 1'b1;
                    n_seen        = 1'b0;
                    n_latched     = bitp_pkg::ERR_NONE;
                    n_state       = bitp_pkg::ST_DONE;
                end
            end
            bitp_pkg::ST_DONE: begin
                if (can_emit) begin
                    mv_last = r_hold_v;
                    n_state = bitp_pkg::ST_IDLE;
                    if (i_q_valid) begin
                        deq     = 1'b1;
                        n_cur   = i_q_item;
                        n_state = bitp_pkg::ST_RUN;
                    end
                end
            end
            default: begin
                n_state = bitp_pkg::ST_IDLE;
            end
        endcase
        if (push) begin
            n_count = r_count + 1'b1;
        end else if (pop) begin
            n_count = cnt_m1;
        end
    end

    // Hold stage keeps the newest result until the item's last one is known
    assign mv       = (emit && r_hold_v) || mv_last;
    assign n_top_ok = !(push || pop || clear);

    always_comb begin
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        n_out    = r_out;
        n_out_v  = r_out_v && !i_out_ready;
        if (mv) begin
            n_out      = r_hold;
            n_out.last = mv_last;
            n_out_v    = 1'b1;
            n_hold_v   = 1'b0;
        end
        if (emit) begin
            n_hold   = em;
            n_hold_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bitp_pkg::ST_IDLE;
            r_count   <= '0;
            r_expect  <= 1'b1;
            r_seen    <= 1'b0;
            r_latched <= bitp_pkg::ERR_NONE;
            r_top_ok  <= 1'b0;
            r_hold_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_expect  <= n_expect;
            r_seen    <= n_seen;
            r_latched <= n_latched;
            r_top_ok  <= n_top_ok;
            r_hold_v  <= n_hold_v;
            r_out_v   <= n_out_v;
        end
        r_cur  <= n_cur;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_count[IW-1:0]] <= push_data;
        end
        r_rd <= r_mem[rd_idx];
    end

    property p_no_push_full;
        @(posedge i_clk) disable iff (!i_rst_n) push |-> !full;
    endproperty
    a_no_push_full: assert property (p_no_push_full)
        else $error("push on a full operator stack");

    property p_pop_valid_top;
        @(posedge i_clk) disable iff (!i_rst_n) pop |-> (has && r_top_ok);
    endproperty
    a_pop_valid_top: assert property (p_pop_valid_top)
        else $error("pop without a settled top of stack");

    property p_emit_room;
        @(posedge i_clk) disable iff (!i_rst_n) (emit && r_hold_v) |-> out_free;
    endproperty
    a_emit_room: assert property (p_emit_room)
        else $error("result overwrites the hold stage");

    property p_final_clears;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == bitp_pkg::ST_FINAL && can_emit) |=>
            (r_count == '0 && r_latched == bitp_pkg::ERR_NONE && r_expect);
    endproperty
    a_final_clears: assert property (p_final_clears)
        else $error("state not cleared after final status");

    property p_last_only_done;
        @(posedge i_clk) disable iff (!i_rst_n)
            mv_last |-> (r_state == bitp_pkg::ST_DONE);
    endproperty
    a_last_only_done: assert property (p_last_only_done)
        else $error("last flag raised outside item completion");

endmodule

@@ sv/boolean_infix_to_postfix.sv @@
// ----------------------------------------------------------------------------
// boolean_infix_to_postfix
// Boolean formula tokens in, shunting-yard postfix tokens, errors and status out.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+-----------------------
//   in      | in        | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//   out     | out       | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// Sequence: in the back end, a token that causes no stack pop is dequeued and
// then executed; the result leaves through the hold stage while the next
// token is dequeued. Each operator popped from the stack adds a wait for the
// registered read port of the stack memory. An end item adds a final state
// for its final status.
// Reset: synchronous, active low; clears control state only. The stack memory
// is not cleared: an entry is only used after it has been written.
// Stalls: the front register and a two-entry queue keep accepting tokens, until
// they fill, while the back end waits on a stalled output; the back end holds in
// place until a transfer frees its output register.
// ----------------------------------------------------------------------------
module boolean_infix_to_postfix #(
    parameter int STACK_DEPTH = bitp_pkg::STACK_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bitp_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bitp_pkg::t_out_item  o_out_item
);

    // Front to queue
    logic                cls_valid;
    logic                cls_ready;
    bitp_pkg::t_cls_item cls_item;

    // Queue to back
    logic                q_valid;
    logic                q_ready;
    bitp_pkg::t_cls_item q_item;

    // Classify tokens and drop the unused action code
    bitp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_cls_valid (cls_valid),
        .i_cls_ready (cls_ready),
        .o_cls_item  (cls_item)
    );

    // Decouple the front from stalls of the back end
    bitp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (cls_valid),
        .o_wr_ready (cls_ready),
        .i_wr_item  (cls_item),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_item  (q_item)
    );

    // Operator stack, error latch, result ordering
    bitp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_item    (q_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
